[rtl/core/pws_pkg.sv]
// shared types, constants and helpers for the perspective warp sampler
// no dependencies
package pws_pkg;

   localparam int MaxSrcWidth  = 512;
   localparam int MaxSrcHeight = 512;
   localparam int FracBits     = 8;
   localparam int ColBits      = $clog2(MaxSrcWidth);
   localparam int RowBits      = $clog2(MaxSrcHeight);
   localparam int AddrBits     = ColBits + RowBits;
   localparam int CoefBits     = 21;
   localparam int NumBits      = 34;
   localparam int DivShift     = 12 + FracBits;
   localparam int DividendBits = NumBits + DivShift;
   localparam int QuoBits      = DividendBits;
   localparam int PixBits      = 24;

   localparam logic [2:0] CSR_ROW_X  = 3'd0;
   localparam logic [2:0] CSR_ROW_Y  = 3'd1;
   localparam logic [2:0] CSR_ROW_W  = 3'd2;
   localparam logic [2:0] CSR_INTERP = 3'd3;
   localparam logic [2:0] CSR_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_HEIGHT = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   typedef struct packed {
      logic                    valid;
      logic                    wr;
      logic                    blank;
      logic [NumBits-1:0]      nx;
      logic [NumBits-1:0]      ny;
      logic [NumBits-1:0]      w;
      logic [AddrBits-1:0]     waddr;
      logic [PixBits-1:0]      wdata;
   } proj_type;

   typedef struct packed {
      logic                    wr;
      logic                    blank;
      logic [NumBits-1:0]      nx;
      logic [NumBits-1:0]      ny;
      logic [NumBits-1:0]      w;
      logic [AddrBits-1:0]     waddr;
      logic [PixBits-1:0]      wdata;
   } qent_type;

   function automatic logic signed [CoefBits-1:0] coef_f(input logic [62:0] row,
                                                          input int k);
      coef_f = row[k*CoefBits +: CoefBits];
   endfunction

endpackage

[rtl/core/pws_front.sv]
// front end: accepts words, registers source pixel writes, projects map coordinates
// depends on pws_pkg
module pws_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic                     in_op,
   input  logic [9:0]               in_x,
   input  logic [9:0]               in_y,
   input  logic [23:0]              in_pix,
   input  logic [62:0]              row_x,
   input  logic [62:0]              row_y,
   input  logic [62:0]              row_w,
   output pws_pkg::proj_type        proj
);
   import pws_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_wr_ff, s1_wr_in;
   logic [AddrBits-1:0] s1_addr_ff;
   logic [PixBits-1:0] s1_pix_ff;
   logic signed [NumBits-1:0] px_ff [3], py_ff [3], pw_ff [3];
   logic signed [NumBits-1:0] sx, sy, sw;
   logic signed [10:0] xs, ys;

   assign xs = {1'b0, in_x};
   assign ys = {1'b0, in_y};
   assign s1_wr_in = in_valid && in_op == OP_WRITE &&
                     {1'b0, in_x} < 11'(MaxSrcWidth) && {1'b0, in_y} < 11'(MaxSrcHeight);
   assign s1_valid_in = (in_valid && in_op == OP_MAP) || s1_wr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_wr_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_wr_ff <= s1_wr_in;
      end
      s1_addr_ff <= {in_y[RowBits-1:0], in_x[ColBits-1:0]};
      s1_pix_ff <= in_pix;
      px_ff[0] <= NumBits'(coef_f(row_x, 0) * xs);
      px_ff[1] <= NumBits'(coef_f(row_x, 1) * ys);
      px_ff[2] <= NumBits'(coef_f(row_x, 2));
      py_ff[0] <= NumBits'(coef_f(row_y, 0) * xs);
      py_ff[1] <= NumBits'(coef_f(row_y, 1) * ys);
      py_ff[2] <= NumBits'(coef_f(row_y, 2));
      pw_ff[0] <= NumBits'(coef_f(row_w, 0) * xs);
      pw_ff[1] <= NumBits'(coef_f(row_w, 1) * ys);
      pw_ff[2] <= NumBits'(coef_f(row_w, 2));
   end

   always_comb begin
      sx = px_ff[0] + px_ff[1] + px_ff[2];
      sy = py_ff[0] + py_ff[1] + py_ff[2];
      sw = pw_ff[0] + pw_ff[1] + pw_ff[2];
      proj.valid = s1_valid_ff;
      proj.wr = s1_wr_ff;
      proj.waddr = s1_addr_ff;
      proj.wdata = s1_pix_ff;
      if (sw < 0) begin
         sx = -sx;
         sy = -sy;
         sw = -sw;
      end
      proj.blank = (sw == 0) || sx < 0 || sy < 0;
      proj.nx = sx;
      proj.ny = sy;
      proj.w  = sw;
   end
endmodule

[rtl/core/pws_queue.sv]
// short queue between projection and sampling back end
// depends on pws_pkg
module pws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pws_pkg::qent_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic [2:0]        count,
   output pws_pkg::qent_type pop_data
);
   import pws_pkg::*;

   qent_type    mem_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;

   assign not_empty = cnt_ff != 3'd0;
   assign count = cnt_ff;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

[rtl/core/pws_back.sv]
// back end: pipelined dividers, bounds, banked frame reads, bilinear blend
// depends on pws_pkg
module pws_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  pws_pkg::qent_type            in_data,
   input  logic                         stall,
   input  logic                         interp,
   input  logic [9:0]                   width,
   input  logic [9:0]                   height,
   output logic                         out_valid,
   output logic [23:0]                  out_pixel,
   output logic                         out_inside
);
   import pws_pkg::*;

   localparam int Stages = QuoBits;
   localparam int BankAddr = AddrBits - 2;

   // restoring divider, one quotient bit per stage; writes ride alongside in order
   logic              dv_ff  [Stages+1];
   logic              dwr_ff [Stages+1];
   logic              db_ff  [Stages+1];
   logic [DividendBits-1:0] dx_ff [Stages+1], dy_ff [Stages+1];
   logic [NumBits:0]  rx_ff  [Stages+1], ry_ff [Stages+1];
   logic [NumBits-1:0] dw_ff [Stages+1];
   logic [AddrBits-1:0] dad_ff [Stages+1];
   logic [PixBits-1:0]  dpx_ff [Stages+1];

   always_comb begin
      dv_ff[0] = in_valid && !in_data.wr;
      dwr_ff[0] = in_valid && in_data.wr;
      db_ff[0] = in_data.blank;
      dx_ff[0] = {in_data.nx, DivShift'(0)};
      dy_ff[0] = {in_data.ny, DivShift'(0)};
      rx_ff[0] = '0;
      ry_ff[0] = '0;
      dw_ff[0] = in_data.w;
      dad_ff[0] = in_data.waddr;
      dpx_ff[0] = in_data.wdata;
   end

   for (genvar g = 0; g < Stages; g++) begin : g_div
      logic [NumBits:0] tx, ty;
      assign tx = {rx_ff[g][NumBits-1:0], dx_ff[g][DividendBits-1]};
      assign ty = {ry_ff[g][NumBits-1:0], dy_ff[g][DividendBits-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
            dwr_ff[g+1] <= 1'b0;
         end else if (!stall) begin
            dv_ff[g+1] <= dv_ff[g];
            dwr_ff[g+1] <= dwr_ff[g];
         end
         if (!stall) begin
            db_ff[g+1] <= db_ff[g];
            dw_ff[g+1] <= dw_ff[g];
            dad_ff[g+1] <= dad_ff[g];
            dpx_ff[g+1] <= dpx_ff[g];
            rx_ff[g+1] <= (tx >= {1'b0, dw_ff[g]}) ? tx - {1'b0, dw_ff[g]} : tx;
            ry_ff[g+1] <= (ty >= {1'b0, dw_ff[g]}) ? ty - {1'b0, dw_ff[g]} : ty;
            dx_ff[g+1] <= {dx_ff[g][DividendBits-2:0], tx >= {1'b0, dw_ff[g]}};
            dy_ff[g+1] <= {dy_ff[g][DividendBits-2:0], ty >= {1'b0, dw_ff[g]}};
         end
      end
   end

   // bounds and neighbour addresses
   logic [QuoBits-1:0] qx, qy;
   logic [9:0]  wd, ht;
   logic        in_b;
   logic [ColBits-1:0] ix, ix1;
   logic [RowBits-1:0] iy, iy1;
   logic [FracBits-1:0] fx, fy;
   assign qx = dx_ff[Stages];
   assign qy = dy_ff[Stages];
   assign wd = (width > 10'(MaxSrcWidth)) ? 10'(MaxSrcWidth) : width;
   assign ht = (height > 10'(MaxSrcHeight)) ? 10'(MaxSrcHeight) : height;
   assign in_b = !db_ff[Stages] &&
                 qx < (QuoBits'(wd) << FracBits) && qy < (QuoBits'(ht) << FracBits);
   assign ix = qx[FracBits +: ColBits];
   assign iy = qy[FracBits +: RowBits];
   assign fx = qx[FracBits-1:0];
   assign fy = qy[FracBits-1:0];
   assign ix1 = ({1'b0, ix} + 1'b1 < (ColBits+1)'(wd)) ? ix + 1'b1
                : ColBits'(wd - 10'd1);
   assign iy1 = ({1'b0, iy} + 1'b1 < (RowBits+1)'(ht)) ? iy + 1'b1
                : RowBits'(ht - 10'd1);

   logic a_v_ff, a_in_ff, a_bil_ff;
   logic [FracBits-1:0] a_fx_ff, a_fy_ff;
   logic a_swx_ff, a_swy_ff;
   logic a_clx_ff, a_cly_ff;

   // four banks by column and row parity; each neighbour lands in its own bank
   logic [ColBits-1:0] ce, co;
   logic [RowBits-1:0] re, ro;
   always_comb begin
      ce = ix[0] ? ix1 : ix;
      co = ix[0] ? ix : ix1;
      re = iy[0] ? iy1 : iy;
      ro = iy[0] ? iy : iy1;
   end

   logic                wr_en;
   logic [AddrBits-1:0] wr_addr;
   logic [PixBits-1:0]  wr_data;
   assign wr_en = dwr_ff[Stages] && !stall;
   assign wr_addr = dad_ff[Stages];
   assign wr_data = dpx_ff[Stages];

   logic [23:0] bank0 [2**BankAddr];
   logic [23:0] bank1 [2**BankAddr];
   logic [23:0] bank2 [2**BankAddr];
   logic [23:0] bank3 [2**BankAddr];
   logic [23:0] rd_ff [4];
   logic [1:0]  wb;
   logic [BankAddr-1:0] wa;
   assign wb = {wr_addr[ColBits], wr_addr[0]};
   assign wa = {wr_addr[AddrBits-1:ColBits+1], wr_addr[ColBits-1:1]};

   logic [BankAddr-1:0] ra [4];
   assign ra[0] = {re[RowBits-1:1], ce[ColBits-1:1]};
   assign ra[1] = {re[RowBits-1:1], co[ColBits-1:1]};
   assign ra[2] = {ro[RowBits-1:1], ce[ColBits-1:1]};
   assign ra[3] = {ro[RowBits-1:1], co[ColBits-1:1]};

   always_ff @(posedge clock) begin
      if (wr_en && wb == 2'd0) bank0[wa] <= wr_data;
      if (wr_en && wb == 2'd1) bank1[wa] <= wr_data;
      if (wr_en && wb == 2'd2) bank2[wa] <= wr_data;
      if (wr_en && wb == 2'd3) bank3[wa] <= wr_data;
      if (!stall) begin
         rd_ff[0] <= bank0[ra[0]];
         rd_ff[1] <= bank1[ra[1]];
         rd_ff[2] <= bank2[ra[2]];
         rd_ff[3] <= bank3[ra[3]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (!stall) a_v_ff <= dv_ff[Stages];
      if (!stall) begin
         a_in_ff  <= in_b;
         a_bil_ff <= interp && (fx != '0 || fy != '0);
         a_fx_ff  <= fx;
         a_fy_ff  <= fy;
         a_swx_ff <= ix[0];
         a_swy_ff <= iy[0];
         a_clx_ff <= ix1 == ix;
         a_cly_ff <= iy1 == iy;
      end
   end

   // unswap banks into p00 p01 p10 p11; a clamped neighbour repeats the edge pixel
   logic [23:0] q [4];
   logic [23:0] p [4];
   always_comb begin
      q[0] = rd_ff[{a_swy_ff, a_swx_ff}];
      q[1] = rd_ff[{a_swy_ff, !a_swx_ff}];
      q[2] = rd_ff[{!a_swy_ff, a_swx_ff}];
      q[3] = rd_ff[{!a_swy_ff, !a_swx_ff}];
      p[0] = q[0];
      p[1] = a_clx_ff ? q[0] : q[1];
      p[2] = a_cly_ff ? q[0] : q[2];
      p[3] = a_clx_ff ? (a_cly_ff ? q[0] : q[2]) : (a_cly_ff ? q[1] : q[3]);
   end

   // weights then per-channel blend
   localparam int WB = 2*FracBits + 1;
   logic [FracBits:0] one_x, one_y;
   assign one_x = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(a_fx_ff);
   assign one_y = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(a_fy_ff);

   logic b_v_ff, b_in_ff, b_bil_ff;
   logic [WB:0] w_ff [4];
   logic [23:0] bp_ff [4];
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (!stall) b_v_ff <= a_v_ff;
      if (!stall) begin
         b_in_ff  <= a_in_ff;
         b_bil_ff <= a_bil_ff;
         w_ff[0] <= (WB+1)'(one_x * one_y);
         w_ff[1] <= (WB+1)'({1'b0, a_fx_ff} * one_y);
         w_ff[2] <= (WB+1)'(one_x * {1'b0, a_fy_ff});
         w_ff[3] <= (WB+1)'({1'b0, a_fx_ff} * {1'b0, a_fy_ff});
         for (int i = 0; i < 4; i++) bp_ff[i] <= p[i];
      end
   end

   logic [WB+9:0] acc [3];
   logic [23:0]   blend;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = (WB+10)'(1 << (2*FracBits-1));
         for (int i = 0; i < 4; i++)
            acc[c] = acc[c] + (WB+10)'(bp_ff[i][8*c +: 8] * w_ff[i]);
         acc[c] = acc[c] >> (2*FracBits);
         blend[8*c +: 8] = (acc[c] > (WB+10)'(255)) ? 8'hff : acc[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (!stall) out_valid <= b_v_ff;
      if (!stall) begin
         out_inside <= b_in_ff;
         out_pixel  <= !b_in_ff ? 24'd0 : (b_bil_ff ? blend : bp_ff[0]);
      end
   end
endmodule

[rtl/core/perspective_warp_sampler.sv]
// top level of the perspective warp sampler: config registers, front, queue, back
// depends on pws_pkg, pws_front, pws_queue, pws_back
//
// channel  dir  fields
// req      in   tdata: opcode, coord_x, coord_y, pixel_in
// rsp      out  tdata: pixel_out, inside_res
// csr      in   we, index, wdata
//
// one word per cycle while the queue has room; a map word's result passes
// through the front register, queue, 54 divider stages, read, weight and output.
// pixel writes travel the same pipeline so maps and writes keep their order.
// the back end stalls as a whole while a result waits; the front keeps taking
// words until the queue is near full. reset is synchronous; the frame is
// undefined until written.
module perspective_warp_sampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode, coord_x, coord_y, pixel_in, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out, inside_res, pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [62:0] csr_wdata
);
   import pws_pkg::*;

   logic [62:0] row_x_ff, row_y_ff, row_w_ff;
   logic        interp_ff;
   logic [9:0]  width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= '0;
         row_y_ff  <= '0;
         row_w_ff  <= '0;
         interp_ff <= 1'b1;
         width_ff  <= 10'd512;
         height_ff <= 10'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X:  row_x_ff  <= csr_wdata;
            CSR_ROW_Y:  row_y_ff  <= csr_wdata;
            CSR_ROW_W:  row_w_ff  <= csr_wdata;
            CSR_INTERP: interp_ff <= csr_wdata[0];
            CSR_WIDTH:  width_ff  <= csr_wdata[9:0];
            CSR_HEIGHT: height_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   logic     acc_w;
   proj_type proj;
   qent_type qin, qout;
   logic     q_ne, stall, pop;
   logic [2:0] q_cnt;
   logic     out_valid, out_inside;
   logic [23:0] out_pixel;

   assign acc_w = req_tvalid && req_tready;
   assign req_tready = q_cnt < 3'd3;

   pws_front u_front (
      .clock(clock), .reset(reset), .in_valid(acc_w),
      .in_op(req_tdata[0]), .in_x(req_tdata[10:1]), .in_y(req_tdata[20:11]),
      .in_pix(req_tdata[44:21]),
      .row_x(row_x_ff), .row_y(row_y_ff), .row_w(row_w_ff),
      .proj(proj)
   );

   assign qin.wr = proj.wr;
   assign qin.blank = proj.blank;
   assign qin.nx = proj.nx;
   assign qin.ny = proj.ny;
   assign qin.w  = proj.w;
   assign qin.waddr = proj.waddr;
   assign qin.wdata = proj.wdata;

   assign stall = rsp_tvalid && !rsp_tready;
   assign pop = q_ne && !stall;

   pws_queue u_queue (
      .clock(clock), .reset(reset), .push(proj.valid), .push_data(qin),
      .pop(pop), .not_empty(q_ne), .count(q_cnt), .pop_data(qout)
   );

   pws_back u_back (
      .clock(clock), .reset(reset), .in_valid(pop), .in_data(qout),
      .stall(stall), .interp(interp_ff), .width(width_ff), .height(height_ff),
      .out_valid(out_valid), .out_pixel(out_pixel), .out_inside(out_inside)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {7'd0, out_inside, out_pixel};

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> rsp_tdata[23:0] == 24'd0)
      else $error("blanked word carries a pixel");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt <= 3'd4) else $error("queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_ne) else $error("pop from empty queue");
endmodule

[tb/tb_perspective_warp_sampler.sv]
// self-checking testbench for perspective_warp_sampler: directed table then random phases
// depends on pws_pkg and the perspective_warp_sampler rtl; holds its own warp predictor
`timescale 1ns / 1ps
module tb_perspective_warp_sampler;
   import pws_pkg::*;

   localparam int FrameDepth = MaxSrcWidth * MaxSrcHeight;

   typedef struct {
      logic [PixBits-1:0] pixel;
      logic               in_frame;
   } sample_type;

   typedef struct {
      logic               op;
      logic [9:0]         x;
      logic [9:0]         y;
      logic [PixBits-1:0] pixel;
      bit                 typed;
      sample_type         want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_ROW_X;
   logic [62:0] csr_wdata = '0;

   perspective_warp_sampler uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("tb_perspective_warp_sampler NOT OK");
      $finish;
   end

   // predictor state
   logic [PixBits-1:0] frame_mem [FrameDepth];
   bit                 frame_set [FrameDepth];
   logic [62:0]        mat_x, mat_y, mat_w;
   logic               interp_on;
   logic [9:0]         src_w, src_h;

   sample_type samples_due [$];
   int      mismatches = 0;
   bit      failed = 0;
   int      burst_left = 0;
   int      miss_addr;

   function automatic longint coef_of(input logic [62:0] row, input int k);
      logic signed [CoefBits-1:0] c;
      c = row[k*CoefBits +: CoefBits];
      return longint'(c);
   endfunction

   function automatic longint row_dot(input logic [62:0] row, input longint x, input longint y);
      return coef_of(row, 0) * x + coef_of(row, 1) * y + coef_of(row, 2);
   endfunction

   function automatic logic [PixBits-1:0] frame_at(input int r, input int c);
      int a;
      a = r * MaxSrcWidth + c;
      if (!frame_set[a] && miss_addr < 0) miss_addr = a;
      return frame_mem[a];
   endfunction

   // projects and samples one output coordinate; miss_addr flags an unwritten read
   function automatic sample_type warp_sample(input logic [9:0] x, input logic [9:0] y);
      sample_type  s;
      longint      nx, ny, w, wd, ht, one, fx, fy, acc;
      logic [63:0] qx, qy;
      int          ix, iy, ix1, iy1;
      logic [PixBits-1:0] p00, p01, p10, p11;
      s.pixel = '0;
      s.in_frame = 1'b0;
      miss_addr = -1;
      nx = row_dot(mat_x, x, y);
      ny = row_dot(mat_y, x, y);
      w = row_dot(mat_w, x, y);
      if (w == 0) return s;
      if (w < 0) begin
         w = -w;
         nx = -nx;
         ny = -ny;
      end
      if (nx < 0 || ny < 0) return s;
      qx = (64'(nx) << DivShift) / 64'(w);
      qy = (64'(ny) << DivShift) / 64'(w);
      wd = (src_w > MaxSrcWidth) ? MaxSrcWidth : src_w;
      ht = (src_h > MaxSrcHeight) ? MaxSrcHeight : src_h;
      if (qx >= 64'(wd << FracBits) || qy >= 64'(ht << FracBits)) return s;
      one = 1 << FracBits;
      ix = int'(qx >> FracBits);
      iy = int'(qy >> FracBits);
      fx = longint'(qx & 64'(one - 1));
      fy = longint'(qy & 64'(one - 1));
      s.in_frame = 1'b1;
      if (!interp_on || (fx == 0 && fy == 0)) begin
         s.pixel = frame_at(iy, ix);
         return s;
      end
      ix1 = (ix + 1 < wd) ? ix + 1 : int'(wd) - 1;
      iy1 = (iy + 1 < ht) ? iy + 1 : int'(ht) - 1;
      p00 = frame_at(iy, ix);
      p01 = frame_at(iy, ix1);
      p10 = frame_at(iy1, ix);
      p11 = frame_at(iy1, ix1);
      for (int ch = 0; ch < 3; ch++) begin
         acc = longint'(p00[8*ch +: 8]) * (one - fx) * (one - fy)
             + longint'(p01[8*ch +: 8]) * fx * (one - fy)
             + longint'(p10[8*ch +: 8]) * (one - fx) * fy
             + longint'(p11[8*ch +: 8]) * fx * fy;
         acc = (acc + (longint'(1) << (2*FracBits - 1))) >> (2*FracBits);
         if (acc > 255) acc = 255;
         s.pixel[8*ch +: 8] = acc[7:0];
      end
      return s;
   endfunction

   task automatic put_word(input logic op, input logic [9:0] x, input logic [9:0] y,
                           input logic [PixBits-1:0] p, input bit typed,
                           input sample_type want);
      int gap;
      sample_type exp_s;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, p, y, x, op};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (op == OP_WRITE) begin
         if (x < MaxSrcWidth && y < MaxSrcHeight) begin
            frame_mem[y * MaxSrcWidth + x] = p;
            frame_set[y * MaxSrcWidth + x] = 1;
         end
      end else begin
         exp_s = typed ? want : warp_sample(x, y);
         samples_due = {samples_due, exp_s};
      end
   endtask

   // writes any unwritten neighbour first so that the map never reads an unset entry
   task automatic map_point(input logic [9:0] x, input logic [9:0] y);
      sample_type s;
      s = warp_sample(x, y);
      while (miss_addr >= 0) begin
         put_word(OP_WRITE, 10'(miss_addr % MaxSrcWidth), 10'(miss_addr / MaxSrcWidth),
                  PixBits'($urandom), 0, s);
         s = warp_sample(x, y);
      end
      put_word(OP_MAP, x, y, PixBits'($urandom), 0, s);
   endtask

   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      burst_left = 0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // registers change only with the pipeline empty
   task automatic csr_write(input logic [2:0] idx, input logic [62:0] val);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      case (idx)
         CSR_ROW_X:  mat_x = val;
         CSR_ROW_Y:  mat_y = val;
         CSR_ROW_W:  mat_w = val;
         CSR_INTERP: interp_on = val[0];
         CSR_WIDTH:  src_w = val[9:0];
         CSR_HEIGHT: src_h = val[9:0];
         default: ;
      endcase
   endtask

   function automatic logic [62:0] pack_row(input longint c0, input longint c1, input longint c2);
      return {c2[20:0], c1[20:0], c0[20:0]};
   endfunction

   // receiver stall pattern
   int rx_count = 0;
   always @(negedge clock) begin
      rx_count <= rx_count + 1;
      case ((rx_count / 97) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (rx_count % 5 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (samples_due.size() == 0) begin
            failed = 1;
            if (mismatches < 10) $display("unexpected word %h", rsp_tdata);
            mismatches++;
         end else begin
            sample_type e;
            e = samples_due.pop_front();
            if (rsp_tdata[23:0] !== e.pixel || rsp_tdata[24] !== e.in_frame) begin
               failed = 1;
               if (mismatches < 10)
                  $display("mismatch: pixel exp %h got %h, inside exp %b got %b",
                           e.pixel, rsp_tdata[23:0], e.in_frame, rsp_tdata[24]);
               mismatches++;
            end
         end
      end
   end

   stim_row_type directed [] = '{
      '{OP_MAP,   10'd0,    10'd0,    24'h0,      1, '{24'h0, 1'b0}},
      '{OP_MAP,   10'd1023, 10'd1023, 24'hFFFFFF, 1, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd0,    10'd0,    24'h000000, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd1,    10'd0,    24'hFFFFFF, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd0,    10'd1,    24'h80FF01, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd1,    10'd1,    24'h123456, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd511,  10'd511,  24'hA5A5A5, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd1023, 10'd1023, 24'hFFFFFF, 0, '{24'h0, 1'b0}},
      '{OP_WRITE, 10'd512,  10'd3,    24'h5A5A5A, 0, '{24'h0, 1'b0}},
      '{OP_MAP,   10'd2,    10'd2,    24'h0,      1, '{24'h0, 1'b0}}
   };

   initial begin
      longint sg, c[9];
      int     n, mode;
      sample_type none;
      none = '{24'h0, 1'b0};
      mat_x = '0; mat_y = '0; mat_w = '0;
      interp_on = 1'b1; src_w = 10'd512; src_h = 10'd512;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // zero matrix: every map is blank
      foreach (directed[i])
         put_word(directed[i].op, directed[i].x, directed[i].y, directed[i].pixel,
                  directed[i].typed, directed[i].want);
      settle();

      // near identity with a quarter-pixel offset, edges and clamping
      csr_write(CSR_ROW_X, pack_row(128, 0, 32));
      csr_write(CSR_ROW_Y, pack_row(0, 128, 32));
      csr_write(CSR_ROW_W, pack_row(0, 0, 1 << 19));
      map_point(10'd0, 10'd0);
      map_point(10'd511, 10'd511);
      map_point(10'd512, 10'd0);
      csr_write(CSR_INTERP, 63'd0);
      map_point(10'd0, 10'd0);
      csr_write(CSR_ROW_X, pack_row(128, 0, 0));
      csr_write(CSR_ROW_Y, pack_row(0, 128, 0));
      csr_write(CSR_INTERP, 63'd1);
      map_point(10'd1, 10'd1);
      map_point(10'd511, 10'd0);
      settle();

      for (int ph = 0; ph < 14; ph++) begin
         mode = ph % 7;
         sg = ($urandom_range(0, 1) == 1) ? -1 : 1;
         c[0] = sg * ($urandom_range(0, 700) - 350);
         c[1] = sg * ($urandom_range(0, 60) - 30);
         c[2] = sg * $urandom_range(0, 40000);
         c[3] = sg * ($urandom_range(0, 60) - 30);
         c[4] = sg * ($urandom_range(0, 700) - 350);
         c[5] = sg * $urandom_range(0, 40000);
         c[6] = sg * ($urandom_range(0, 200) - 100);
         c[7] = sg * ($urandom_range(0, 200) - 100);
         c[8] = sg * $urandom_range(1 << 17, (1 << 20) - 1);
         if (mode == 6) begin
            csr_write(CSR_ROW_X, {$urandom, $urandom});
            csr_write(CSR_ROW_Y, (ph == 6) ? '1 : {$urandom, $urandom});
            csr_write(CSR_ROW_W, (ph == 6) ? '1 : {$urandom, $urandom});
         end else begin
            csr_write(CSR_ROW_X, pack_row(c[0], c[1], c[2]));
            csr_write(CSR_ROW_Y, pack_row(c[3], c[4], c[5]));
            csr_write(CSR_ROW_W, pack_row(c[6], c[7], c[8]));
         end
         csr_write(CSR_INTERP, 63'($urandom_range(0, 3) != 0));
         case (mode)
            0: begin csr_write(CSR_WIDTH, 63'd1);    csr_write(CSR_HEIGHT, 63'd1);    end
            1: begin csr_write(CSR_WIDTH, 63'd512);  csr_write(CSR_HEIGHT, 63'd512);  end
            2: begin csr_write(CSR_WIDTH, 63'd1023); csr_write(CSR_HEIGHT, 63'd700);  end
            3: begin csr_write(CSR_WIDTH, 63'd0);    csr_write(CSR_HEIGHT, 63'd40);   end
            default: begin
               csr_write(CSR_WIDTH, 63'($urandom_range(1, 64)));
               csr_write(CSR_HEIGHT, 63'($urandom_range(1, 64)));
            end
         endcase
         n = $urandom_range(30, 45);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
               put_word(OP_WRITE, 10'($urandom), 10'($urandom), PixBits'($urandom), 0, none);
            else if ($urandom_range(0, 2) == 0)
               map_point(10'($urandom), 10'($urandom));
            else
               map_point(10'($urandom_range(0, 80)), 10'($urandom_range(0, 80)));
         end
         settle();
      end

      if (samples_due.size() != 0) failed = 1;
      if (!failed)
         $display("tb_perspective_warp_sampler OK");
      else
         $display("tb_perspective_warp_sampler NOT OK");
      $finish;
   end

endmodule

[perspective_warp_sampler.f]
rtl/core/pws_pkg.sv
rtl/core/pws_front.sv
rtl/core/pws_queue.sv
rtl/core/pws_back.sv
rtl/core/perspective_warp_sampler.sv
tb/tb_perspective_warp_sampler.sv
